// File: hw/rtl/ldq_pkg.sv
// Shared types, constants and helpers for the linked deque block.
// No dependencies; imported by every module of the block.
`default_nettype none

package ldq_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LINK_W = 7;
  localparam int CAP_W  = 7;
  localparam int DATA_W = 32;
  localparam int QDEPTH = 2;

  localparam logic [LINK_W-1:0] NIL = 7'h7F;

  // operation codes on in_func
  localparam logic [2:0] FN_CLEAR      = 3'd0;
  localparam logic [2:0] FN_PUSH_FRONT = 3'd1;
  localparam logic [2:0] FN_PUSH_BACK  = 3'd2;
  localparam logic [2:0] FN_POP_FRONT  = 3'd3;
  localparam logic [2:0] FN_POP_BACK   = 3'd4;
  localparam logic [2:0] FN_WALK_FWD   = 3'd5;
  localparam logic [2:0] FN_WALK_BWD   = 3'd6;

  // command kinds after classification
  localparam logic [1:0] K_CLEAR = 2'd0;
  localparam logic [1:0] K_PUSH  = 2'd1;
  localparam logic [1:0] K_POP   = 2'd2;
  localparam logic [1:0] K_WALK  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_NOPUSH = 2'd3;

  typedef struct packed {
    logic [1:0]               kind;
    logic                     at_back;  // back end of the list (or backward walk)
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]               status;
    logic                     has_item;
    logic signed [DATA_W-1:0] item;
    logic                     last;
  } res_t;

  function automatic logic is_slot(input logic [LINK_W-1:0] p);
    return p < LINK_W'(DEPTH);
  endfunction

  // forward link of an entry untouched since the last rebuild
  function automatic logic [LINK_W-1:0] nl_default(input logic [ADDR_W-1:0] a,
                                                   input logic [CAP_W-1:0] n);
    logic [LINK_W-1:0] nx;
    nx = LINK_W'(a) + LINK_W'(1);
    return (nx < n) ? nx : NIL;
  endfunction

  function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] r;
    r = c;
    if (c == '0) r = CAP_W'(1);
    else if (c > CAP_W'(DEPTH)) r = CAP_W'(DEPTH);
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ldq_front.sv
// Front end: takes transactions, decodes the operation, queues commands.
// Depends on ldq_pkg.
`default_nettype none

module ldq_front
  import ldq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [2:0]               in_func,
  input  wire logic signed [DATA_W-1:0] in_item_value,
  output logic                          q_valid,
  output cmd_t                          q_cmd,
  input  wire logic                     q_pop
);

  localparam int PW = $clog2(QDEPTH);

  cmd_t            fifo_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]     count_r, count_nxt;
  logic            take, known;
  cmd_t            dec;

  // decode; unused codes are dropped here and never reach the back end
  always_comb begin
    known       = 1'b1;
    dec.kind    = K_CLEAR;
    dec.at_back = 1'b0;
    dec.value   = in_item_value;
    case (in_func)
      FN_CLEAR:      dec.kind = K_CLEAR;
      FN_PUSH_FRONT: dec.kind = K_PUSH;
      FN_PUSH_BACK:  begin dec.kind = K_PUSH; dec.at_back = 1'b1; end
      FN_POP_FRONT:  dec.kind = K_POP;
      FN_POP_BACK:   begin dec.kind = K_POP; dec.at_back = 1'b1; end
      FN_WALK_FWD:   dec.kind = K_WALK;
      FN_WALK_BWD:   begin dec.kind = K_WALK; dec.at_back = 1'b1; end
      default:       known = 1'b0;
    endcase
  end

  assign busy    = (count_r == (PW+1)'(QDEPTH));
  assign take    = start && !busy && known;
  assign q_valid = (count_r != '0);
  assign q_cmd   = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = take  ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + (PW+1)'(take) - (PW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) fifo_r[wr_ptr_r] <= dec;
  end

endmodule

`default_nettype wire

// File: hw/rtl/ldq_back.sv
// Back end: list engine with value and link memories, head, tail, free chain.
// Depends on ldq_pkg.
`default_nettype none

module ldq_back
  import ldq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [CAP_W-1:0] capacity,
  input  wire logic             q_valid,
  input  wire cmd_t             q_cmd,
  output logic                  q_pop,
  output logic                  res_valid,
  output res_t                  res
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PUSH_WR  = 4'd1;
  localparam logic [3:0] S_PUSH_FIX = 4'd2;
  localparam logic [3:0] S_POP_WR   = 4'd3;
  localparam logic [3:0] S_POP_FREE = 4'd4;
  localparam logic [3:0] S_WALK_EM  = 4'd5;

  logic signed [DATA_W-1:0] vs_mem [DEPTH];
  logic [LINK_W-1:0]        nl_mem [DEPTH];
  logic [LINK_W-1:0]        pl_mem [DEPTH];

  logic [3:0]               state_r, state_nxt;
  cmd_t                     cmd_r, cmd_nxt;
  logic [ADDR_W-1:0]        s_r, s_nxt, aux_r, aux_nxt, k_r, k_nxt;
  logic signed [DATA_W-1:0] v_r, v_nxt;
  logic [LINK_W-1:0]        head_r, head_nxt, tail_r, tail_nxt, free_r, free_nxt;
  logic                     pushed_r, pushed_nxt;
  logic [CAP_W-1:0]         fill_r, fill_nxt;
  logic [DEPTH-1:0]         nl_vld_r, nl_vld_nxt;
  logic                     clear_all;

  logic [ADDR_W-1:0]        rd_addr, rd_addr_q_r;
  logic signed [DATA_W-1:0] vs_rd_r;
  logic [LINK_W-1:0]        nl_rd_r, pl_rd_r, nl_data, walk_nx, p;
  logic                     nl_rd_vld_r, fin;

  logic                     vs_we, nl_we, pl_we;
  logic [ADDR_W-1:0]        vs_wa, nl_wa, pl_wa;
  logic signed [DATA_W-1:0] vs_wd;
  logic [LINK_W-1:0]        nl_wd, pl_wd;

  logic                     emit;
  res_t                     emit_res;
  logic                     res_valid_r;
  res_t                     res_r;

  // entries not rewritten since the last rebuild read as the rebuilt chain
  assign nl_data = nl_rd_vld_r ? nl_rd_r : nl_default(rd_addr_q_r, fill_r);
  assign walk_nx = cmd_r.at_back ? pl_rd_r : nl_data;
  assign fin     = !is_slot(walk_nx) || (k_r == ADDR_W'(DEPTH - 1));
  assign p       = q_cmd.at_back ? tail_r : head_r;

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    s_nxt      = s_r;
    aux_nxt    = aux_r;
    k_nxt      = k_r;
    v_nxt      = v_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    free_nxt   = free_r;
    pushed_nxt = pushed_r;
    fill_nxt   = fill_r;
    clear_all  = 1'b0;
    q_pop      = 1'b0;
    rd_addr    = '0;
    vs_we = 1'b0; vs_wa = s_r; vs_wd = cmd_r.value;
    nl_we = 1'b0; nl_wa = s_r; nl_wd = NIL;
    pl_we = 1'b0; pl_wa = s_r; pl_wd = NIL;
    emit              = 1'b0;
    emit_res.status   = ST_OK;
    emit_res.has_item = 1'b0;
    emit_res.item     = '0;
    emit_res.last     = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          case (q_cmd.kind)
            K_CLEAR: begin
              clear_all = 1'b1;
              head_nxt  = NIL;
              tail_nxt  = NIL;
              free_nxt  = '0;
              fill_nxt  = clamp_cap(capacity);
              emit      = 1'b1;
            end
            K_PUSH: begin
              pushed_nxt = 1'b1;
              if (!is_slot(free_r)) begin
                emit            = 1'b1;
                emit_res.status = ST_FULL;
              end else begin
                s_nxt     = free_r[ADDR_W-1:0];
                rd_addr   = free_r[ADDR_W-1:0];
                state_nxt = S_PUSH_WR;
              end
            end
            K_POP: begin
              if (!pushed_r) begin
                emit            = 1'b1;
                emit_res.status = ST_NOPUSH;
              end else if (!is_slot(head_r) || !is_slot(tail_r)) begin
                emit            = 1'b1;
                emit_res.status = ST_EMPTY;
              end else begin
                s_nxt     = p[ADDR_W-1:0];
                rd_addr   = p[ADDR_W-1:0];
                state_nxt = S_POP_WR;
              end
            end
            K_WALK: begin
              if (!is_slot(p)) begin
                emit            = 1'b1;
                emit_res.status = ST_EMPTY;
              end else begin
                rd_addr   = p[ADDR_W-1:0];
                k_nxt     = '0;
                state_nxt = S_WALK_EM;
              end
            end
            default: ;
          endcase
        end
      end

      S_PUSH_WR: begin
        free_nxt = nl_data;
        vs_we    = 1'b1;
        if (!is_slot(head_r) || !is_slot(tail_r)) begin
          nl_we     = 1'b1;
          pl_we     = 1'b1;
          head_nxt  = LINK_W'(s_r);
          tail_nxt  = LINK_W'(s_r);
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else if (!cmd_r.at_back) begin
          pl_we     = 1'b1;
          nl_we     = 1'b1;
          nl_wd     = head_r;
          aux_nxt   = head_r[ADDR_W-1:0];
          head_nxt  = LINK_W'(s_r);
          state_nxt = S_PUSH_FIX;
        end else begin
          nl_we     = 1'b1;
          nl_wa     = tail_r[ADDR_W-1:0];
          nl_wd     = LINK_W'(s_r);
          pl_we     = 1'b1;
          pl_wd     = tail_r;
          tail_nxt  = LINK_W'(s_r);
          state_nxt = S_PUSH_FIX;
        end
      end

      S_PUSH_FIX: begin
        if (!cmd_r.at_back) begin
          pl_we = 1'b1;
          pl_wa = aux_r;
          pl_wd = LINK_W'(s_r);
        end else begin
          nl_we = 1'b1;   // new tail terminates the chain
        end
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end

      S_POP_WR: begin
        v_nxt = vs_rd_r;
        if (head_r == tail_r) begin
          head_nxt = NIL;
          tail_nxt = NIL;
        end else if (!cmd_r.at_back) begin
          head_nxt = nl_data;
          if (is_slot(nl_data)) begin
            pl_we = 1'b1;
            pl_wa = nl_data[ADDR_W-1:0];
          end else begin
            tail_nxt = NIL;
          end
        end else begin
          tail_nxt = pl_rd_r;
          if (is_slot(pl_rd_r)) begin
            nl_we = 1'b1;
            nl_wa = pl_rd_r[ADDR_W-1:0];
          end else begin
            head_nxt = NIL;
          end
        end
        state_nxt = S_POP_FREE;
      end

      S_POP_FREE: begin
        nl_we             = 1'b1;
        nl_wd             = free_r;
        free_nxt          = LINK_W'(s_r);
        emit              = 1'b1;
        emit_res.has_item = 1'b1;
        emit_res.item     = v_r;
        state_nxt         = S_IDLE;
      end

      S_WALK_EM: begin
        emit              = 1'b1;
        emit_res.has_item = 1'b1;
        emit_res.item     = vs_rd_r;
        emit_res.last     = fin;
        if (fin) begin
          state_nxt = S_IDLE;
        end else begin
          rd_addr = walk_nx[ADDR_W-1:0];
          k_nxt   = k_r + ADDR_W'(1);
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    nl_vld_nxt = nl_vld_r;
    if (clear_all) nl_vld_nxt = '0;
    else if (nl_we) nl_vld_nxt[nl_wa] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NIL;
      tail_r      <= NIL;
      free_r      <= '0;
      pushed_r    <= 1'b0;
      fill_r      <= CAP_W'(DEPTH);
      nl_vld_r    <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_r      <= free_nxt;
      pushed_r    <= pushed_nxt;
      fill_r      <= fill_nxt;
      nl_vld_r    <= nl_vld_nxt;
      res_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    s_r   <= s_nxt;
    aux_r <= aux_nxt;
    k_r   <= k_nxt;
    v_r   <= v_nxt;
    res_r <= emit_res;
  end

  // memories: one read address shared by all three with registered read data, one write each
  always_ff @(posedge clk) begin
    vs_rd_r     <= vs_mem[rd_addr];
    nl_rd_r     <= nl_mem[rd_addr];
    pl_rd_r     <= pl_mem[rd_addr];
    nl_rd_vld_r <= nl_vld_r[rd_addr];
    rd_addr_q_r <= rd_addr;
    if (vs_we) vs_mem[vs_wa] <= vs_wd;
    if (nl_we) nl_mem[nl_wa] <= nl_wd;
    if (pl_we) pl_mem[pl_wa] <= pl_wd;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

`ifndef NO_ASSERTIONS
  a_ends_agree: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == NIL) == (tail_r == NIL))
    else $error("head and tail disagree on list emptiness");

  a_mid_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && !res_r.last |-> res_r.has_item && (res_r.status == ST_OK))
    else $error("non-final result without an item");

  a_walk_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && !res_r.last |=> res_valid_r)
    else $error("gap inside a walk");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_IDLE) || !q_pop)
    else $error("command taken while engine busy");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/linked_deque_with_free_list.sv
// Top level of the linked deque: capacity register, front end and list engine.
// Depends on ldq_pkg, ldq_front and ldq_back.
// The engine runs one command at a time: clear and errors are answered from idle, a push
//   passes S_PUSH_WR (then S_PUSH_FIX unless the list was empty), a pop S_POP_WR and
//   S_POP_FREE, and a walk emits its elements from S_WALK_EM; each result is registered.
//   The front end queues commands meanwhile, so a new transaction can land while it works.
// Results cannot be stalled. Reset (synchronous, rst_n low) empties the list, rebuilds a
//   free chain of 64 entries without a clearing pass and sets capacity to 64.
`default_nettype none

module linked_deque_with_free_list
  import ldq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // command transactions
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [2:0]               in_func,
  input  wire logic signed [DATA_W-1:0] in_item_value,
  // capacity write channel
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CAP_W-1:0]         cfg_capacity,
  // results
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic                          out_has_item,
  output logic signed [DATA_W-1:0]      out_item_out,
  output logic                          out_last
);

  logic [CAP_W-1:0] capacity_r;
  logic             q_valid, q_pop, res_valid;
  cmd_t             q_cmd;
  res_t             res;

  // Capacity only takes effect at the next clear, so the write channel is
  // always ready; the engine samples the register when a clear executes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_W'(DEPTH);
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_capacity;
    end
  end

  // Front end: decodes the opcode, drops unused codes, and holds up to two
  // commands so a new transaction can land while the engine is still busy.
  ldq_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_item_value (in_item_value),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop)
  );

  // List engine: value store and links in memories, one command at a time;
  // its result register is the output stage.
  ldq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .capacity  (capacity_r),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_valid    = res_valid;
  assign out_status   = res.status;
  assign out_has_item = res.has_item;
  assign out_item_out = res.item;
  assign out_last     = res.last;

endmodule

`default_nettype wire
